// ===== rtl/core/fzi_pkg.sv =====
// fzi_pkg.sv: shared constants and types of the two-input fuzzy inference core
`timescale 1ns / 1ps

package fzi_pkg;

    // default sizes of the rule table and of the fixed-point fraction
    localparam int NUM_SETS_DEF  = 7;
    localparam int FRAC_BITS_DEF = 16;

    // fixed field widths of the channels and the register port
    localparam int DATA_W   = 32;
    localparam int IDX_IN_W = 3;
    localparam int RULE_W   = 4;
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic signed [DATA_W-1:0] GAIN_ONE = 32'sd65536;
    localparam logic signed [DATA_W-1:0] ZERO_VAL = 32'sd0;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_OFFSET  = 3'd0,
        CFG_INPUT_GAIN    = 3'd1,
        CFG_CHANGE_OFFSET = 3'd2,
        CFG_CHANGE_GAIN   = 3'd3,
        CFG_OUTPUT_GAIN   = 3'd4,
        CFG_OUTPUT_BIAS   = 3'd5
    } cfg_reg_t;

    // item kinds
    localparam logic ACT_INFER = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

endpackage

// ===== rtl/core/fzi_in_if.sv =====
// fzi_in_if.sv: input channel of the fuzzy inference core
`timescale 1ns / 1ps

interface fzi_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  action;
    logic signed [fzi_pkg::DATA_W-1:0]     error_value;
    logic signed [fzi_pkg::DATA_W-1:0]     error_change;
    logic        [fzi_pkg::IDX_IN_W-1:0]   rule_row;
    logic        [fzi_pkg::IDX_IN_W-1:0]   rule_column;
    logic signed [fzi_pkg::RULE_W-1:0]     rule_value;

    modport source (output valid, action, error_value, error_change,
                    rule_row, rule_column, rule_value, input ready);
    modport sink   (input valid, action, error_value, error_change,
                    rule_row, rule_column, rule_value, output ready);
endinterface

// ===== rtl/core/fzi_out_if.sv =====
// fzi_out_if.sv: result channel of the fuzzy inference core
`timescale 1ns / 1ps

interface fzi_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [fzi_pkg::DATA_W-1:0] fuzzy_output;

    modport source (output valid, fuzzy_output, input ready);
    modport sink   (input valid, fuzzy_output, output ready);
endinterface

// ===== rtl/core/fuzzy_inference_two_input_core.sv =====
// fuzzy_inference_two_input_core.sv: pipelined two-input fuzzy inference core
`timescale 1ns / 1ps
//
// Usage
//   sample : input channel. action 0 is an inference beat carrying error_value
//            and error_change (signed Q16.16); action 1 writes rule_value into
//            rule entry (rule_row, rule_column) and gives no result.
//   result : one fuzzy_output beat (signed Q16.16, saturated) per inference.
//   cfg    : cfg_write / cfg_index / cfg_data load the six scale registers;
//            write them only while no beat is in flight.
// Timing
//   eight register stages, and the result is driven from the last. One beat per
//   cycle is accepted while the pipe is not stalled; the rule table is four
//   banks by row and column parity, so the four entries around an input pair
//   are read in the same cycle, one port per bank.
// Reset
//   stage valid bits are cleared and the scale registers take their reset
//   values; the rule table holds nothing until written.
// Stall
//   when result.ready is low with a result waiting, the whole pipe holds and
//   sample.ready drops; nothing is lost or repeated.

module fuzzy_inference_two_input_core #(
    parameter int NUM_SETS  = fzi_pkg::NUM_SETS_DEF,
    parameter int FRAC_BITS = fzi_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    fzi_in_if.sink                               sample,
    fzi_out_if.source                            result,
    input  logic                                 cfg_write,
    input  logic [fzi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fzi_pkg::DATA_W-1:0]           cfg_data
);
    import fzi_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int IDX_W  = $clog2(NUM_SETS);
    localparam int HALF   = (NUM_SETS + 1) / 2;
    localparam int BDEPTH = HALF * HALF;
    localparam int BA_W   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int Y_W    = DATA_W + 1;
    localparam int P_W    = Y_W + DATA_W;
    localparam int Q_W    = P_W - F;
    localparam int U_W    = F + 5;
    localparam int W_W    = F + 2;
    localparam int WP_W   = 2 * W_W;
    localparam int NUM_W  = 2 * F + 6;
    localparam int CEN_W  = F + 4;
    localparam int M_W    = CEN_W + DATA_W;
    localparam int S_W    = M_W - F + 1;
    localparam logic [U_W-1:0] LIM = U_W'(NUM_SETS - 1) << F;
    localparam logic [W_W-1:0] W_FULL = W_W'(1) << (F + 1);
    localparam logic signed [S_W-1:0] SAT_MAX = S_W'(64'sh7FFF_FFFF);
    localparam logic signed [S_W-1:0] SAT_MIN = -S_W'(64'sh8000_0000);

    // configuration registers
    logic signed [DATA_W-1:0] in_off_reg, in_gain_reg, ch_off_reg, ch_gain_reg;
    logic signed [DATA_W-1:0] out_gain_reg, out_bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_off_reg   <= ZERO_VAL;
            in_gain_reg  <= GAIN_ONE;
            ch_off_reg   <= ZERO_VAL;
            ch_gain_reg  <= GAIN_ONE;
            out_gain_reg <= GAIN_ONE;
            out_bias_reg <= ZERO_VAL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INPUT_OFFSET:  in_off_reg   <= cfg_data;
                CFG_INPUT_GAIN:    in_gain_reg  <= cfg_data;
                CFG_CHANGE_OFFSET: ch_off_reg   <= cfg_data;
                CFG_CHANGE_GAIN:   ch_gain_reg  <= cfg_data;
                CFG_OUTPUT_GAIN:   out_gain_reg <= cfg_data;
                CFG_OUTPUT_BIAS:   out_bias_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipe advance
    logic [8:1] v_reg;
    logic       en;
    assign en           = !v_reg[8] || result.ready;
    assign sample.ready = en;

    // stage payload
    logic                      act1_reg, act2_reg, act3_reg, act4_reg;
    logic [IDX_IN_W-1:0]       row1_reg, row2_reg, row3_reg;
    logic [IDX_IN_W-1:0]       col1_reg, col2_reg, col3_reg;
    logic signed [RULE_W-1:0]  val1_reg, val2_reg, val3_reg;
    logic signed [Y_W-1:0]     ye1_reg, yc1_reg;
    logic [P_W-1:0]            pe2_reg, pc2_reg;
    logic                      ne2_reg, nc2_reg;
    logic [IDX_W-1:0]          ke3_reg, kc3_reg;
    logic [F:0]                fe3_reg, fc3_reg;
    logic signed [RULE_W-1:0]  rd4_reg [4];
    logic [W_W-1:0]            wr4_reg [4];
    logic [W_W-1:0]            wc4_reg [4];
    logic signed [RULE_W-1:0]  t5_reg [4];
    logic [WP_W-1:0]           wp5_reg [4];
    logic signed [NUM_W-1:0]   num6_reg;
    logic signed [M_W-1:0]     m7_reg;
    logic signed [DATA_W-1:0]  out8_reg;

    // valid bits; only inference beats go past the table stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg[1] <= sample.valid;
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3];
            v_reg[5] <= v_reg[4] && (act4_reg == ACT_INFER);
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
            v_reg[8] <= v_reg[7];
        end
    end

    // stage 2 and 3 helpers: magnitudes, clamp and set position
    logic [Y_W-1:0]      ye_mag, yc_mag;
    logic [DATA_W-1:0]   ge_mag, gc_mag;
    logic [Q_W-1:0]      qe, qc;
    logic [U_W-1:0]      qe_c, qc_c, ue, uc;

    always_comb
    begin
        ye_mag = ye1_reg[Y_W-1] ? Y_W'(-ye1_reg) : Y_W'(ye1_reg);
        yc_mag = yc1_reg[Y_W-1] ? Y_W'(-yc1_reg) : Y_W'(yc1_reg);
        ge_mag = in_gain_reg[DATA_W-1] ? DATA_W'(-in_gain_reg) : DATA_W'(in_gain_reg);
        gc_mag = ch_gain_reg[DATA_W-1] ? DATA_W'(-ch_gain_reg) : DATA_W'(ch_gain_reg);
        qe     = pe2_reg[P_W-1:F];
        qc     = pc2_reg[P_W-1:F];
        qe_c   = (qe > Q_W'(LIM)) ? LIM : U_W'(qe);
        qc_c   = (qc > Q_W'(LIM)) ? LIM : U_W'(qc);
        ue     = ne2_reg ? (LIM - qe_c) : (LIM + qe_c);
        uc     = nc2_reg ? (LIM - qc_c) : (LIM + qc_c);
    end

    // stage 4 helpers: bank rows, columns, addresses and weights
    logic [IDX_W:0]   re_b [4];
    logic [IDX_W:0]   cc_b [4];
    logic [BA_W-1:0]  rd_addr [4];
    logic [W_W-1:0]   wr_b [4];
    logic [W_W-1:0]   wc_b [4];
    logic [BA_W-1:0]  wr_addr;
    logic [1:0]       wr_bank;
    logic             wr_en;

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            re_b[b] = (ke3_reg[0] == b[1]) ? {1'b0, ke3_reg} : ({1'b0, ke3_reg} + 1'b1);
            cc_b[b] = (kc3_reg[0] == b[0]) ? {1'b0, kc3_reg} : ({1'b0, kc3_reg} + 1'b1);
            rd_addr[b] = BA_W'((32'(re_b[b] >> 1) * HALF) + 32'(cc_b[b] >> 1));
            wr_b[b] = (re_b[b] == {1'b0, ke3_reg}) ? (W_FULL - W_W'(fe3_reg)) : W_W'(fe3_reg);
            wc_b[b] = (cc_b[b] == {1'b0, kc3_reg}) ? (W_FULL - W_W'(fc3_reg)) : W_W'(fc3_reg);
        end
        wr_addr = BA_W'((32'(row3_reg >> 1) * HALF) + 32'(col3_reg >> 1));
        wr_bank = {row3_reg[0], col3_reg[0]};
        wr_en   = en && v_reg[3] && (act3_reg == ACT_WRITE) &&
                  (32'(row3_reg) < NUM_SETS) && (32'(col3_reg) < NUM_SETS);
    end

    // rule table: four banks split by row and column parity
    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic signed [RULE_W-1:0] mem [BDEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(g)))
            begin
                mem[wr_addr] <= val3_reg;
            end
            if (en)
            begin
                rd4_reg[g] <= mem[rd_addr[g]];
            end
        end
    end

    // stage 6, 7 and 8 helpers
    logic signed [NUM_W-1:0] num_sum;
    logic signed [CEN_W-1:0] cen;
    logic signed [S_W-1:0]   sum8;

    always_comb
    begin
        num_sum = '0;
        for (int b = 0; b < 4; b++)
        begin
            if (wp5_reg[b] != '0)
            begin
                num_sum = num_sum + NUM_W'(t5_reg[b]) * NUM_W'($signed({1'b0, wp5_reg[b]}));
            end
        end
        cen  = CEN_W'(num6_reg >>> (F + 2));
        sum8 = S_W'(m7_reg >>> F) + S_W'(out_bias_reg);
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // offset removal
            act1_reg <= sample.action;
            row1_reg <= sample.rule_row;
            col1_reg <= sample.rule_column;
            val1_reg <= sample.rule_value;
            ye1_reg  <= Y_W'(sample.error_value) - Y_W'(in_off_reg);
            yc1_reg  <= Y_W'(sample.error_change) - Y_W'(ch_off_reg);
            // gain multiply on magnitudes
            act2_reg <= act1_reg;
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
            val2_reg <= val1_reg;
            pe2_reg  <= P_W'(ye_mag) * P_W'(ge_mag);
            pc2_reg  <= P_W'(yc_mag) * P_W'(gc_mag);
            ne2_reg  <= ye1_reg[Y_W-1] ^ in_gain_reg[DATA_W-1];
            nc2_reg  <= yc1_reg[Y_W-1] ^ ch_gain_reg[DATA_W-1];
            // clamp and locate the lower set and fraction
            act3_reg <= act2_reg;
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
            val3_reg <= val2_reg;
            ke3_reg  <= ue[F+1 +: IDX_W];
            kc3_reg  <= uc[F+1 +: IDX_W];
            fe3_reg  <= ue[F:0];
            fc3_reg  <= uc[F:0];
            // table read, weights per bank
            act4_reg <= act3_reg;
            for (int b = 0; b < 4; b++)
            begin
                wr4_reg[b] <= wr_b[b];
                wc4_reg[b] <= wc_b[b];
                // weight products
                t5_reg[b]  <= rd4_reg[b];
                wp5_reg[b] <= WP_W'(wr4_reg[b]) * WP_W'(wc4_reg[b]);
            end
            // weighted sum
            num6_reg <= num_sum;
            // centroid times output gain
            m7_reg   <= M_W'(cen) * M_W'(out_gain_reg);
            // bias and saturation
            if (sum8 > SAT_MAX)
                out8_reg <= DATA_W'(SAT_MAX);
            else if (sum8 < SAT_MIN)
                out8_reg <= DATA_W'(SAT_MIN);
            else
                out8_reg <= DATA_W'(sum8);
        end
    end

    assign result.valid        = v_reg[8];
    assign result.fuzzy_output = out8_reg;

    // the two memberships of each input share the full weight
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[4] && (act4_reg == ACT_INFER) |->
        ((wr4_reg[0] + wr4_reg[3]) == W_FULL) && ((wc4_reg[0] + wc4_reg[3]) == W_FULL))
        else $error("membership weights do not sum to full scale");

    // clamped position never leaves the set range
    a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] && (act3_reg == ACT_INFER) |->
        (32'(ke3_reg) < NUM_SETS) && (32'(kc3_reg) < NUM_SETS))
        else $error("lower set index beyond the table");

    // a held stage keeps its valid bits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipe moved while stalled");

endmodule

// ===== tb/tb.sv =====
// tb.sv: self-checking testbench of the two-input fuzzy inference core
`timescale 1ns / 1ps

module tb;
    import fzi_pkg::*;

    localparam int NSETS = NUM_SETS_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int PIPE_WAIT = 16;
    localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S_MIN = 32'sh80000000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    cfg_reg_t cfg_index;
    logic [DATA_W-1:0] cfg_data;

    fzi_in_if  sample ();
    fzi_out_if result ();

    fuzzy_inference_two_input_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample.sink),
        .result    (result.source),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // own copy of the scale registers and the rule table
    longint in_off, in_gain, chg_off, chg_gain, out_gain, out_bias;
    logic signed [RULE_W-1:0] rules [NSETS*NSETS];

    logic signed [31:0] pending_outputs [$];
    int  mismatches;
    bit  idle_on;
    bit  hold_req;

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard limit on run length
    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // scaled input onto the universe, truncated magnitude then clamped
    function automatic longint scale_to_universe(longint x, longint off, longint gain);
        longint y;
        bit neg;
        bit [63:0] ym, gm, q, lim;
        y   = x - off;
        neg = (y < 0) != (gain < 0);
        ym  = (y < 0) ? -y : y;
        gm  = (gain < 0) ? -gain : gain;
        q   = (ym * gm) >> FRAC;
        lim = 64'(NSETS - 1) << FRAC;
        if (q > lim)
            q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // set memberships, triangles of half-width two on centres two apart
    function automatic void memberships(longint n, output longint w [NSETS]);
        longint two, c, d;
        two = longint'(2) << FRAC;
        for (int k = 0; k < NSETS; k++)
        begin
            c = longint'(2 * k - (NSETS - 1)) <<< FRAC;
            d = n - c;
            if (d < 0)
                d = -d;
            w[k] = (d < two) ? two - d : 0;
        end
    endfunction

    // weighted centroid mapped to the physical output, saturated
    function automatic logic signed [31:0] defuzzified(logic signed [31:0] ev,
                                                      logic signed [31:0] ec);
        longint we [NSETS];
        longint wc [NSETS];
        longint num, cen, res;
        memberships(scale_to_universe(ev, in_off, in_gain), we);
        memberships(scale_to_universe(ec, chg_off, chg_gain), wc);
        num = 0;
        for (int i = 0; i < NSETS; i++)
            for (int j = 0; j < NSETS; j++)
                if (we[i] != 0 && wc[j] != 0)
                    num += longint'(rules[i*NSETS + j]) * (we[i] * wc[j]);
        cen = num >>> (FRAC + 2);
        res = ((cen * out_gain) >>> FRAC) + out_bias;
        if (res > longint'(S_MAX))
            res = S_MAX;
        if (res < longint'(S_MIN))
            res = S_MIN;
        return res[31:0];
    endfunction

    // one input beat, with an optional idle burst before it
    task automatic send_beat(logic act, logic signed [31:0] ev, logic signed [31:0] ec,
                             logic [2:0] row, logic [2:0] col, logic signed [3:0] val);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        sample.valid        <= 1'b1;
        sample.action       <= act;
        sample.error_value  <= ev;
        sample.error_change <= ec;
        sample.rule_row     <= row;
        sample.rule_column  <= col;
        sample.rule_value   <= val;
        do
            @(posedge clk);
        while (!sample.ready);
        if (act == ACT_WRITE)
        begin
            if (row < NSETS && col < NSETS)
                rules[row*NSETS + col] = val;
        end
        else
            pending_outputs.push_back(defuzzified(ev, ec));
    endtask

    task automatic infer(logic signed [31:0] ev, logic signed [31:0] ec);
        send_beat(ACT_INFER, ev, ec, 3'($urandom), 3'($urandom), 4'($urandom));
    endtask

    task automatic write_rule(logic [2:0] row, logic [2:0] col, logic signed [3:0] val);
        send_beat(ACT_WRITE, $urandom, $urandom, row, col, val);
    endtask

    function automatic logic signed [3:0] rand_rule();
        return 4'($signed($urandom_range(0, 12)) - 6);
    endfunction

    // input value: mostly within the universe, some across the full range
    function automatic logic signed [31:0] rand_input();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return ($signed($urandom_range(0, 12)) - 6) <<< 16;
            default: return $signed($urandom_range(0, 32'h000e0000)) - 32'sh00070000;
        endcase
    endfunction

    // drop valid, wait for the pipe to empty and settle
    task automatic drain();
        sample.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic signed [31:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            CFG_INPUT_OFFSET:  in_off   = v;
            CFG_INPUT_GAIN:    in_gain  = v;
            CFG_CHANGE_OFFSET: chg_off  = v;
            CFG_CHANGE_GAIN:   chg_gain = v;
            CFG_OUTPUT_GAIN:   out_gain = v;
            CFG_OUTPUT_BIAS:   out_bias = v;
            default: ;
        endcase
    endtask

    task automatic load_regs(logic signed [31:0] io, logic signed [31:0] ig,
                             logic signed [31:0] co, logic signed [31:0] cg,
                             logic signed [31:0] og, logic signed [31:0] ob);
        drain();
        write_reg(CFG_INPUT_OFFSET, io);
        write_reg(CFG_INPUT_GAIN, ig);
        write_reg(CFG_CHANGE_OFFSET, co);
        write_reg(CFG_CHANGE_GAIN, cg);
        write_reg(CFG_OUTPUT_GAIN, og);
        write_reg(CFG_OUTPUT_BIAS, ob);
        cfg_write <= 1'b0;
    endtask

    // random mix: inferences with the odd rule rewrite
    task automatic random_beats(int n);
        for (int k = 0; k < n; k++)
            if ($urandom_range(0, 9) == 0)
                write_rule(3'($urandom), 3'($urandom), rand_rule());
            else
                infer(rand_input(), rand_input());
    endtask

    // fill every entry, plus writes outside the table that must be ignored
    task automatic test_rule_fill();
        for (int i = 0; i < NSETS; i++)
            for (int j = 0; j < NSETS; j++)
                write_rule(3'(i), 3'(j),
                           (i + j == 0) ? -4'sd6 : (i + j == 1) ? 4'sd6 : rand_rule());
        write_rule(3'd7, 3'd2, 4'sd5);
        write_rule(3'd1, 3'd7, -4'sd5);
        write_rule(3'd7, 3'd7, 4'sd1);
    endtask

    // field extremes, centres, points between centres, clamping
    task automatic test_directed();
        infer(0, 0);
        infer(S_MAX, S_MIN);
        infer(S_MIN, S_MAX);
        infer(32'sh00060000, -32'sh00060000);
        infer(-32'sh00060000, 32'sh00060000);
        infer(32'sh00010000, 32'sh00030000);
        infer(32'sh00038000, -32'sh00018000);
        infer(-1, 1);
        infer(32'sh00070000, -32'sh00070000);
        infer(32'sh0005ffff, -32'sh0005ffff);
        infer(32'sh55555555, 32'shaaaaaaaa);
        infer(32'shaaaaaaaa, 32'sh55555555);
    endtask

    // several register settings, extremes among them
    task automatic test_settings();
        load_regs(32'sh00008000, 32'sh00020000, -32'sh00004000, 32'sh00018000,
                  32'sh00030000, 32'sh00100000);
        random_beats(150);
        load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_beats(100);
        load_regs(S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX);
        random_beats(60);
        load_regs(S_MIN, S_MIN, S_MAX, S_MAX, S_MIN, S_MIN);
        random_beats(60);
        load_regs(0, -32'sh00010000, 32'sh00001000, -32'sh00004000,
                  -32'sh00200000, -32'sh01000000);
        random_beats(150);
        load_regs(0, 32'sh00010000, 0, 32'sh00010000, 32'sh00010000, 0);
        random_beats(150);
    endtask

    // long result stall while the sender keeps offering
    task automatic test_backpressure();
        hold_req = 1'b1;
        random_beats(60);
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        drain();
        idle_on = 1'b0;
        random_beats(200);
    endtask

    // result ready, with idle bursts and the long hold
    initial
    begin
        result.ready <= 1'b0;
        @(posedge rst_n);
        result.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result.ready <= 1'b0;
                repeat (300) @(posedge clk);
                result.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result.ready <= 1'b1;
            end
        end
    end

    // result check against the oldest expected output
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("fuzzy_output unexpected beat, got %0d", result.fuzzy_output);
                mismatches++;
            end
            else
            begin
                if (result.fuzzy_output !== pending_outputs[0])
                begin
                    $error("fuzzy_output expected %0d got %0d",
                           pending_outputs[0], result.fuzzy_output);
                    mismatches++;
                end
                void'(pending_outputs.pop_front());
            end
        end
    end

    // test sequence
    initial
    begin
        sample.valid        <= 1'b0;
        sample.action       <= ACT_INFER;
        sample.error_value  <= '0;
        sample.error_change <= '0;
        sample.rule_row     <= '0;
        sample.rule_column  <= '0;
        sample.rule_value   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_INPUT_OFFSET;
        cfg_data  <= '0;
        in_off = 0; in_gain = GAIN_ONE; chg_off = 0; chg_gain = GAIN_ONE;
        out_gain = GAIN_ONE; out_bias = 0;
        foreach (rules[i])
            rules[i] = '0;
        mismatches = 0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        @(posedge rst_n);
        @(posedge clk);

        test_rule_fill();
        test_directed();
        test_settings();
        test_backpressure();
        test_full_rate();

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== fuzzy_inference_two_input_core.f =====
rtl/core/fzi_pkg.sv
rtl/core/fzi_in_if.sv
rtl/core/fzi_out_if.sv
rtl/core/fuzzy_inference_two_input_core.sv
tb/tb.sv
